### rtl/ffba_pkg.sv
// Shared opcodes, field widths and defaults of the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int POOL_WORDS_DEF = 1024;
  localparam int POOL_RST_WORDS = 1024;
  localparam int POOL_MIN_WORDS = 3;

  localparam int OPCODE_W  = 2;
  localparam int BYTES_W   = 14;
  localparam int INDEX_W   = 10;
  localparam int CFG_W     = 11;
  localparam int REQ_W     = 12;

  localparam logic [BYTES_W-1:0] BYTES_SAT = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

endpackage

### rtl/first_fit_block_allocator_core.sv
// First-fit block allocator core: header memory, walk sequencer and result register.
// Depends on ffba_pkg.
//
// The pool is a memory of one header per word, walked block by block by address
// adders and size comparators under a sequencer. One word is taken at a time.
// Each visited header is read from memory, then used. A query walks every block once;
// an allocation runs the largest-block pass, then walks blocks first-fit and merges
// free neighbours where needed; a free walks the blocks up to the target. Each word
// ends by loading the result register.
// After reset and after every pool_words write the block writes the single free
// block header before it takes a new word; no clearing pass is run.
module first_fit_block_allocator_core
  import ffba_pkg::*;
#(
  parameter int POOL_WORDS = POOL_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [BYTES_W-1:0]  in_request_bytes,
  input  logic [INDEX_W-1:0]  in_block_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic [INDEX_W-1:0]  out_payload_index,
  output logic [BYTES_W-1:0]  out_largest_bytes,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_pool_words
);

  localparam int PW_W   = $clog2(POOL_WORDS + 1);
  localparam int AW     = $clog2(POOL_WORDS);
  localparam int CW     = ((PW_W > REQ_W) ? PW_W : REQ_W) + 4;
  localparam int PW_RST = (POOL_WORDS < POOL_RST_WORDS) ? POOL_WORDS : POOL_RST_WORDS;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_FMT   = 13'b0000000000010,
    S_LWALK = 13'b0000000000100,
    S_LUSE  = 13'b0000000001000,
    S_AHEAD = 13'b0000000010000,
    S_ALOAD = 13'b0000000100000,
    S_ACHK  = 13'b0000001000000,
    S_AMRG  = 13'b0000010000000,
    S_ADEC  = 13'b0000100000000,
    S_ASET  = 13'b0001000000000,
    S_FWALK = 13'b0010000000000,
    S_FUSE  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic            used;
    logic [PW_W-1:0] size;
  } hdr_t;

  state_t               state_r, state_nxt;
  logic [PW_W-1:0]      pw_r, pw_nxt;
  logic [PW_W-1:0]      pos_r, pos_nxt;
  logic [PW_W-1:0]      cur_size_r, cur_size_nxt;
  logic                 cur_used_r, cur_used_nxt;
  logic [PW_W-1:0]      best_r, best_nxt;
  logic [REQ_W-1:0]     req_r, req_nxt;
  logic [INDEX_W-1:0]   target_r, target_nxt;
  opcode_t              op_r, op_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic [INDEX_W-1:0]   res_pay_r, res_pay_nxt;
  logic [BYTES_W-1:0]   res_big_r, res_big_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r;
  logic [INDEX_W-1:0]   out_pay_r;
  logic [BYTES_W-1:0]   out_big_r;

  hdr_t                 mem [POOL_WORDS];
  hdr_t                 mem_q;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  hdr_t                 wr_data;

  logic [CW-1:0]        pos_w, size_w, q_size_w, req_w, pw_w;
  logic [CW-1:0]        next_w, cur_next_w, big_w;
  logic [CW-1:0]        cfg_w;
  logic                 at_end, in_acc, cfg_acc;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;

  assign pos_w      = CW'(pos_r);
  assign size_w     = CW'(cur_size_r);
  assign q_size_w   = CW'(mem_q.size);
  assign req_w      = CW'(req_r);
  assign pw_w       = CW'(pw_r);
  assign at_end     = (pos_w + CW'(1)) >= pw_w;
  assign next_w     = pos_w + q_size_w + CW'(1);
  assign cur_next_w = pos_w + size_w + CW'(1);
  assign big_w      = CW'(best_r) << 3;
  assign cfg_w      = CW'(cfg_pool_words);

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_payload_index = out_pay_r;
  assign out_largest_bytes = out_big_r;

  // Sequence the header walks
  always_comb begin
    state_nxt    = state_r;
    pw_nxt       = pw_r;
    pos_nxt      = pos_r;
    cur_size_nxt = cur_size_r;
    cur_used_nxt = cur_used_r;
    best_nxt     = best_r;
    req_nxt      = req_r;
    target_nxt   = target_r;
    op_nxt       = op_r;
    res_ok_nxt   = res_ok_r;
    res_pay_nxt  = res_pay_r;
    res_big_nxt  = res_big_r;
    rd_addr      = pos_r[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = pos_r[AW-1:0];
    wr_data      = '{used: 1'b0, size: cur_size_r};
    case (state_r)
      S_IDLE: begin
        if (cfg_acc) begin
          if (cfg_w < CW'(POOL_MIN_WORDS)) begin
            pw_nxt = PW_W'(POOL_MIN_WORDS);
          end else if (cfg_w > CW'(POOL_WORDS)) begin
            pw_nxt = PW_W'(POOL_WORDS);
          end else begin
            pw_nxt = cfg_w[PW_W-1:0];
          end
          state_nxt = S_FMT;
        end else if (in_acc) begin
          op_nxt      = opcode_t'(in_opcode);
          req_nxt     = REQ_W'((CW'(in_request_bytes) + CW'(7)) >> 3);
          target_nxt  = in_block_index - INDEX_W'(1);
          pos_nxt     = '0;
          best_nxt    = '0;
          res_ok_nxt  = 1'b0;
          res_pay_nxt = '0;
          res_big_nxt = '0;
          case (opcode_t'(in_opcode))
            OP_ALLOC, OP_QUERY: state_nxt = S_LWALK;
            OP_FREE: begin
              state_nxt = (in_block_index == '0) ? S_DONE : S_FWALK;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_FMT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = '{used: 1'b0, size: pw_r - PW_W'(2)};
        state_nxt = S_IDLE;
      end
      // Largest free block pass
      S_LWALK: begin
        if (at_end) begin
          if (op_r == OP_QUERY) begin
            res_ok_nxt  = 1'b1;
            res_big_nxt = (big_w > CW'(BYTES_SAT)) ? BYTES_SAT : big_w[BYTES_W-1:0];
            state_nxt   = S_DONE;
          end else if (req_w > CW'(best_r)) begin
            state_nxt = S_DONE;
          end else begin
            pos_nxt   = '0;
            state_nxt = S_AHEAD;
          end
        end else begin
          state_nxt = S_LUSE;
        end
      end
      S_LUSE: begin
        if (!mem_q.used && mem_q.size > best_r) best_nxt = mem_q.size;
        pos_nxt   = next_w[PW_W-1:0];
        state_nxt = S_LWALK;
      end
      // First-fit walk with merging and split
      S_AHEAD: begin
        state_nxt = at_end ? S_DONE : S_ALOAD;
      end
      S_ALOAD: begin
        cur_size_nxt = mem_q.size;
        cur_used_nxt = mem_q.used;
        state_nxt    = S_ACHK;
      end
      S_ACHK: begin
        rd_addr = cur_next_w[AW-1:0];
        if (!cur_used_r && cur_size_r != '0 && size_w < req_w) begin
          state_nxt = ((cur_next_w + CW'(1)) >= pw_w) ? S_ADEC : S_AMRG;
        end else begin
          state_nxt = S_ADEC;
        end
      end
      S_AMRG: begin
        if (mem_q.used || mem_q.size == '0) begin
          state_nxt = S_ADEC;
        end else begin
          cur_size_nxt = PW_W'(size_w + q_size_w + CW'(1));
          wr_en        = 1'b1;
          wr_data      = '{used: 1'b0, size: cur_size_nxt};
          state_nxt    = S_ACHK;
        end
      end
      S_ADEC: begin
        if (!cur_used_r && size_w >= req_w) begin
          res_ok_nxt  = 1'b1;
          res_pay_nxt = INDEX_W'(pos_w + CW'(1));
          wr_en       = 1'b1;
          if (size_w > req_w + CW'(1)) begin
            wr_addr   = AW'(pos_w + req_w + CW'(1));
            wr_data   = '{used: 1'b0, size: PW_W'(size_w - req_w - CW'(1))};
            state_nxt = S_ASET;
          end else begin
            wr_data   = '{used: 1'b1, size: cur_size_r};
            state_nxt = S_DONE;
          end
        end else begin
          pos_nxt   = cur_next_w[PW_W-1:0];
          state_nxt = S_AHEAD;
        end
      end
      S_ASET: begin
        wr_en     = 1'b1;
        wr_data   = '{used: 1'b1, size: PW_W'(req_r)};
        state_nxt = S_DONE;
      end
      // Free walk up to the target header
      S_FWALK: begin
        if (at_end || pos_w > CW'(target_r)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FUSE;
        end
      end
      S_FUSE: begin
        if (pos_w == CW'(target_r)) begin
          if (mem_q.used) begin
            wr_en      = 1'b1;
            wr_data    = '{used: 1'b0, size: mem_q.size};
            res_ok_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          pos_nxt   = next_w[PW_W-1:0];
          state_nxt = S_FWALK;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) out_valid_nxt = 1'b1;
  end

  // Header memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    mem_q <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FMT;
      pw_r        <= PW_W'(PW_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pw_r        <= pw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    cur_size_r <= cur_size_nxt;
    cur_used_r <= cur_used_nxt;
    best_r     <= best_nxt;
    req_r      <= req_nxt;
    target_r   <= target_nxt;
    op_r       <= op_nxt;
    res_ok_r   <= res_ok_nxt;
    res_pay_r  <= res_pay_nxt;
    res_big_r  <= res_big_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_ok_r  <= res_ok_r;
      out_pay_r <= res_pay_r;
      out_big_r <= res_big_r;
    end
  end

`ifndef ASSERT_OFF
  a_cfg_format: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> state_r == S_FMT)
    else $error("pool write did not start a format");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word raised outside done state");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> state_r == S_IDLE && !cfg_valid)
    else $error("input word taken while busy");
`endif

endmodule

### verif/first_fit_block_allocator_checker.sv
// Checker for the first-fit block allocator: watches the in, out and cfg channels,
// keeps its own header pool model and compares each result word. Depends on ffba_pkg.
module first_fit_block_allocator_checker
  import ffba_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [BYTES_W-1:0]  in_request_bytes,
  input  logic [INDEX_W-1:0]  in_block_index,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                out_ok,
  input  logic [INDEX_W-1:0]  out_payload_index,
  input  logic [BYTES_W-1:0]  out_largest_bytes,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_pool_words,
  output int                  fail_count,
  output int                  pending_count
);

  typedef struct packed {
    logic                ok;
    logic [INDEX_W-1:0]  payload_index;
    logic [BYTES_W-1:0]  largest_bytes;
  } alloc_result_t;

  int unsigned hdr_size [POOL_WORDS_DEF];
  bit          hdr_used [POOL_WORDS_DEF];
  bit          hdr_last [POOL_WORDS_DEF];
  int unsigned pool_len;
  alloc_result_t result_queue[$];

  // Rebuild the pool as one free block and a sentinel
  function automatic void format_pool();
    for (int i = 0; i < POOL_WORDS_DEF; i++) begin
      hdr_size[i] = 0;
      hdr_used[i] = 0;
      hdr_last[i] = 0;
    end
    hdr_size[0] = pool_len - 2;
    hdr_last[pool_len-1] = 1;
  endfunction

  function automatic bit at_end(int unsigned pos);
    return pos >= pool_len - 1 || hdr_last[pos];
  endfunction

  function automatic int unsigned largest_free_words();
    int unsigned pos;
    int unsigned best;
    pos = 0;
    best = 0;
    while (!at_end(pos)) begin
      if (!hdr_used[pos] && hdr_size[pos] > best) best = hdr_size[pos];
      pos = pos + hdr_size[pos] + 1;
    end
    return best;
  endfunction

  // First-fit walk with merge-on-demand and split; returns header position or -1
  function automatic int first_fit_alloc(int unsigned req);
    int unsigned pos;
    int unsigned nxt;
    pos = 0;
    if (req > largest_free_words()) return -1;
    while (!at_end(pos)) begin
      if (!hdr_used[pos] && hdr_size[pos] > 0) begin
        while (hdr_size[pos] < req) begin
          nxt = pos + hdr_size[pos] + 1;
          if (at_end(nxt) || hdr_used[nxt] || hdr_size[nxt] == 0) break;
          hdr_size[pos] += hdr_size[nxt] + 1;
        end
      end
      if (!hdr_used[pos] && hdr_size[pos] >= req) begin
        if (hdr_size[pos] > req + 1) begin
          hdr_size[pos+req+1] = hdr_size[pos] - req - 1;
          hdr_used[pos+req+1] = 0;
          hdr_last[pos+req+1] = 0;
          hdr_size[pos] = req;
        end
        hdr_used[pos] = 1;
        return pos;
      end
      pos = pos + hdr_size[pos] + 1;
    end
    return -1;
  endfunction

  function automatic bit release_block(int unsigned idx);
    int unsigned pos;
    pos = 0;
    if (idx == 0) return 0;
    while (!at_end(pos)) begin
      if (pos == idx - 1) begin
        if (!hdr_used[pos]) return 0;
        hdr_used[pos] = 0;
        return 1;
      end
      if (pos > idx - 1) return 0;
      pos = pos + hdr_size[pos] + 1;
    end
    return 0;
  endfunction

  function automatic alloc_result_t predict_result(logic [OPCODE_W-1:0] op,
      logic [BYTES_W-1:0] nbytes, logic [INDEX_W-1:0] idx);
    alloc_result_t r;
    int hdr;
    int unsigned b;
    r = '0;
    case (opcode_t'(op))
      OP_ALLOC: begin
        hdr = first_fit_alloc((int'(nbytes) + 7) >> 3);
        if (hdr >= 0) begin
          r.ok = 1;
          r.payload_index = INDEX_W'(hdr + 1);
        end
      end
      OP_FREE:  r.ok = release_block(idx);
      OP_QUERY: begin
        b = largest_free_words() * 8;
        r.largest_bytes = (b > 16383) ? BYTES_SAT : BYTES_W'(b);
        r.ok = 1;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign pending_count = result_queue.size();

  // Track config writes, accepted words and compare results
  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    int unsigned v;
    if (!rst_n) begin
      pool_len = POOL_RST_WORDS;
      format_pool();
      result_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        v = cfg_pool_words;
        if (v < POOL_MIN_WORDS) v = POOL_MIN_WORDS;
        if (v > POOL_WORDS_DEF) v = POOL_WORDS_DEF;
        pool_len = v;
        format_pool();
      end
      if (in_valid && !in_stall)
        result_queue.push_back(predict_result(in_opcode, in_request_bytes, in_block_index));
      if (out_valid && !out_stall) begin
        got = '{out_ok, out_payload_index, out_largest_bytes};
        if (result_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = result_queue.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### verif/first_fit_block_allocator_core_test.sv
// Top of the first-fit allocator testbench: clock, reset, stimulus and verdict.
// Depends on ffba_pkg, first_fit_block_allocator_core and the checker.
module first_fit_block_allocator_core_test;
  import ffba_pkg::*;

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_valid = 0;
  logic                in_stall;
  logic [OPCODE_W-1:0] in_opcode = '0;
  logic [BYTES_W-1:0]  in_request_bytes = '0;
  logic [INDEX_W-1:0]  in_block_index = '0;
  logic                out_valid;
  logic                out_stall = 0;
  logic                out_ok;
  logic [INDEX_W-1:0]  out_payload_index;
  logic [BYTES_W-1:0]  out_largest_bytes;
  logic                cfg_valid = 0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_pool_words = '0;
  int                  fail_count;
  int                  pending_count;
  bit                  quiet_tail = 0;
  bit                  stim_done = 0;
  int unsigned         live_blocks[$];

  always #5 clk = ~clk;

  first_fit_block_allocator_core u_dut (.*);

  first_fit_block_allocator_checker u_chk (.*);

  // Stall the result side in random bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
    end
  end

  // Send one word and hold it until accepted, with an optional leading gap
  task automatic send_word(logic [OPCODE_W-1:0] op, logic [BYTES_W-1:0] nb,
      logic [INDEX_W-1:0] idx);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_request_bytes <= nb;
    in_block_index <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic set_pool(logic [CFG_W-1:0] words);
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_pool_words <= words;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    live_blocks.delete();
    repeat (2) @(posedge clk);
  endtask

  function automatic int u_chk_live();
    return live_blocks.size();
  endfunction

  task automatic random_phase(int count, int max_bytes, bit tail);
    int r;
    int unsigned k;
    for (int i = 0; i < count; i++) begin
      if (tail && i > count - 40) quiet_tail = 1;
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_word(OP_ALLOC, BYTES_W'($urandom_range(0, max_bytes)), INDEX_W'($urandom));
      end else if (r < 80 && u_chk_live() > 0) begin
        k = $urandom_range(0, u_chk_live() - 1);
        send_word(OP_FREE, BYTES_W'($urandom), INDEX_W'(live_blocks[k]));
      end else if (r < 90) begin
        send_word(OP_FREE, BYTES_W'($urandom), INDEX_W'($urandom));
      end else if (r < 98) begin
        send_word(OP_QUERY, BYTES_W'($urandom), INDEX_W'($urandom));
      end else begin
        send_word(OP_NONE, BYTES_W'($urandom), INDEX_W'($urandom));
      end
    end
  endtask

  // Collect granted payload indexes so frees mostly hit real blocks
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_ok && out_payload_index != 0) begin
      live_blocks.push_back(out_payload_index);
      if (live_blocks.size() > 64) void'(live_blocks.pop_front());
    end
  end

  // Stimulus
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes and special cases at reset size, then at the smallest, a small and the largest pool size
    send_word(OP_QUERY, '0, '0);
    send_word(OP_ALLOC, 14'd8192, '0);
    send_word(OP_ALLOC, '1, '0);
    send_word(OP_ALLOC, 14'd0, '0);
    send_word(OP_ALLOC, 14'd1, '0);
    send_word(OP_ALLOC, 14'd16, '0);
    send_word(OP_FREE, '0, 10'd0);
    send_word(OP_FREE, '0, 10'd1);
    send_word(OP_FREE, '0, 10'd1);
    send_word(OP_FREE, '0, 10'd3);
    send_word(OP_FREE, '0, '1);
    send_word(OP_ALLOC, 14'd40, '0);
    send_word(OP_NONE, '1, '1);
    send_word(OP_QUERY, '1, '1);
    set_pool(11'd0);
    send_word(OP_QUERY, '0, '0);
    send_word(OP_ALLOC, 14'd8, '0);
    send_word(OP_ALLOC, 14'd0, '0);
    set_pool(11'd6);
    send_word(OP_ALLOC, 14'd24, '0);
    send_word(OP_ALLOC, 14'd16, '0);
    set_pool('1);
    send_word(OP_QUERY, '0, '0);
    // random phases over several pool sizes
    random_phase(300, 256, 1'b0);
    set_pool(11'd40);
    random_phase(300, 120, 1'b0);
    set_pool(11'd3);
    random_phase(100, 16, 1'b0);
    set_pool(11'd200);
    random_phase(400, 400, 1'b0);
    set_pool(11'd1024);
    random_phase(750, 8192, 1'b1);
    in_valid <= 0;
    stim_done = 1;
  end

  // Drain and verdict
  initial begin
    wait (stim_done);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("status: fail");
    $finish;
  end

endmodule
